/* sv/lgs_pkg.sv */
`default_nettype none

package lgs_pkg;

	// board geometry
	localparam int MAX_SIDE = 32;
	localparam int SIDE_W   = 6;
	localparam int POS_W    = $clog2(MAX_SIDE);

	// result slots held for one item, in delivery order
	localparam int NUM_SLOTS = 4;
	localparam int SLOT_CNT_W = $clog2(NUM_SLOTS + 1);

	// neighbor counts of the B3/S23 rule
	localparam logic [3:0] NB_SURVIVE = 4'd2;
	localparam logic [3:0] NB_BIRTH   = 4'd3;

	// window neighbor masks: column k at bits 3k..3k+2, oldest row lowest
	localparam logic [8:0] UPPER_NB_MASK = 9'h1EF;
	localparam logic [8:0] LOWER_NB_MASK = 9'h196;

	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [SIDE_W-1:0]     side_t;
	typedef logic [SLOT_CNT_W-1:0] slot_cnt_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic advance;
	} lgs_cmd_t;

	// datapath to controller
	typedef struct packed {
		slot_cnt_t new_count;
	} lgs_status_t;

	function automatic logic [3:0] count9(input logic [8:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 9; i++) begin
			n = n + {3'd0, v[i]};
		end
		return n;
	endfunction

	function automatic logic life_rule(input logic alive, input logic [3:0] n);
		logic res;
		if (alive) begin
			res = (n == NB_SURVIVE) || (n == NB_BIRTH);
		end else begin
			res = (n == NB_BIRTH);
		end
		return res;
	endfunction

	// next state of the middle cell of the upper (row r-1) line
	function automatic logic upper_center(input logic [8:0] w);
		return life_rule(w[4], count9(w & UPPER_NB_MASK));
	endfunction

	// next state of the middle cell of the bottom row, nothing below it
	function automatic logic lower_center(input logic [8:0] w);
		return life_rule(w[5], count9(w & LOWER_NB_MASK));
	endfunction

endpackage

`default_nettype wire

/* sv/lgs_datapath.sv */
`default_nettype none

module lgs_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire lgs_pkg::side_t       cfg_wr_data,
	input  wire logic                 cell_alive,
	input  wire logic                 frame_start,
	input  wire lgs_pkg::lgs_cmd_t    cmd,
	output lgs_pkg::lgs_status_t      sts,
	output logic                      next_alive,
	output lgs_pkg::pos_t             out_row,
	output lgs_pkg::pos_t             out_column,
	output logic                      frame_end,
	output logic                      any_alive
);

	// configuration and stream state
	lgs_pkg::side_t                  board_side_q;
	logic [lgs_pkg::MAX_SIDE-1:0]    above_q;
	logic [lgs_pkg::MAX_SIDE-1:0]    cur_q;
	logic [8:0]                      win_q;
	lgs_pkg::pos_t                   row_q;
	lgs_pkg::pos_t                   col_q;
	logic                            life_q;

	// pending results of the last item
	logic [lgs_pkg::NUM_SLOTS-1:0]   mask_q;
	logic [lgs_pkg::NUM_SLOTS-1:0]   vals_q;
	lgs_pkg::pos_t                   rowu_q;
	lgs_pkg::pos_t                   rowl_q;
	lgs_pkg::pos_t                   colp_q;
	lgs_pkg::pos_t                   cold_q;
	logic                            any_q;

	lgs_pkg::side_t                  side;
	lgs_pkg::side_t                  side_m1_full;
	lgs_pkg::pos_t                   side_m1;
	logic                            restart;
	lgs_pkg::pos_t                   r;
	lgs_pkg::pos_t                   c;
	logic                            a_bit;
	logic                            b_bit;
	logic [8:0]                      w;
	logic [8:0]                      wz;
	logic                            last_row;
	logic                            last_col;
	logic [lgs_pkg::NUM_SLOTS-1:0]   mask_n;
	logic [lgs_pkg::NUM_SLOTS-1:0]   vals_n;
	logic                            life_base;
	logic                            life_n;
	lgs_pkg::pos_t                   row_n;
	lgs_pkg::pos_t                   col_n;

	// side in use, clamped to 1..MAX_SIDE
	always_comb begin
		if (board_side_q == '0) begin
			side = lgs_pkg::SIDE_W'(1);
		end else if (board_side_q > lgs_pkg::SIDE_W'(lgs_pkg::MAX_SIDE)) begin
			side = lgs_pkg::SIDE_W'(lgs_pkg::MAX_SIDE);
		end else begin
			side = board_side_q;
		end
		side_m1_full = side - lgs_pkg::SIDE_W'(1);
		side_m1      = side_m1_full[lgs_pkg::POS_W-1:0];
	end

	// position of the incoming cell
	always_comb begin
		restart = frame_start
			|| ({1'b0, row_q} >= side)
			|| ({1'b0, col_q} >= side);
		r = restart ? '0 : row_q;
		c = restart ? '0 : col_q;
		last_row = (r == side_m1);
		last_col = (c == side_m1);
	end

	// window column and shifted window
	always_comb begin
		a_bit = (r > lgs_pkg::POS_W'(1)) ? above_q[c] : 1'b0;
		b_bit = (r != '0) ? cur_q[c] : 1'b0;
		if (c == '0) begin
			w = {cell_alive, b_bit, a_bit, 6'd0};
		end else begin
			w = {cell_alive, b_bit, a_bit, win_q[8:3]};
		end
		wz = {3'd0, w[8:3]};
	end

	// results caused by this cell, in delivery order
	always_comb begin
		mask_n[0] = (c != '0) && (r != '0);
		mask_n[1] = (c != '0) && last_row;
		mask_n[2] = last_col && (r != '0);
		mask_n[3] = last_col && last_row;
		vals_n[0] = lgs_pkg::upper_center(w);
		vals_n[1] = lgs_pkg::lower_center(w);
		vals_n[2] = lgs_pkg::upper_center(wz);
		vals_n[3] = lgs_pkg::lower_center(wz);
		sts.new_count = lgs_pkg::SLOT_CNT_W'(mask_n[0]) + lgs_pkg::SLOT_CNT_W'(mask_n[1])
			+ lgs_pkg::SLOT_CNT_W'(mask_n[2]) + lgs_pkg::SLOT_CNT_W'(mask_n[3]);
		life_base = ((r == '0) && (c == '0)) ? 1'b0 : life_q;
		life_n    = life_base | (|(mask_n & vals_n));
	end

	// next input position
	always_comb begin
		if (last_col) begin
			col_n = '0;
			row_n = last_row ? '0 : r + lgs_pkg::POS_W'(1);
		end else begin
			col_n = c + lgs_pkg::POS_W'(1);
			row_n = r;
		end
	end

	// stream state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_side_q <= lgs_pkg::SIDE_W'(lgs_pkg::MAX_SIDE);
			above_q      <= '0;
			cur_q        <= '0;
			win_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			life_q       <= 1'b0;
			mask_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				board_side_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				above_q[c] <= cur_q[c];
				cur_q[c]   <= cell_alive;
				win_q      <= w;
				row_q      <= row_n;
				col_q      <= col_n;
				life_q     <= life_n;
				mask_q     <= mask_n;
			end else if (cmd.advance) begin
				mask_q <= mask_q & (mask_q - lgs_pkg::NUM_SLOTS'(1));
			end
		end
	end

	// result payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vals_q <= vals_n;
			rowu_q <= r - lgs_pkg::POS_W'(1);
			rowl_q <= r;
			colp_q <= c - lgs_pkg::POS_W'(1);
			cold_q <= side_m1;
			any_q  <= life_n;
		end
	end

	// oldest pending result goes out first
	always_comb begin
		frame_end = 1'b0;
		if (mask_q[0]) begin
			next_alive = vals_q[0];
			out_row    = rowu_q;
			out_column = colp_q;
		end else if (mask_q[1]) begin
			next_alive = vals_q[1];
			out_row    = rowl_q;
			out_column = colp_q;
		end else if (mask_q[2]) begin
			next_alive = vals_q[2];
			out_row    = rowu_q;
			out_column = cold_q;
		end else begin
			next_alive = vals_q[3];
			out_row    = rowl_q;
			out_column = cold_q;
			frame_end  = mask_q[3];
		end
		any_alive = frame_end & any_q;
	end

	// pending slots match the count handed to the controller
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> ($countones(mask_q) == $past(sts.new_count)))
		else $error("pending result slots differ from reported count");

	// bottom-row results always sit on the last row of the board
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_q[1] || mask_q[3]) |-> (rowl_q == cold_q))
		else $error("bottom-row result not on last board row");

endmodule

`default_nettype wire

/* sv/lgs_ctrl.sv */
`default_nettype none

module lgs_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	input  wire lgs_pkg::lgs_status_t  sts,
	output lgs_pkg::lgs_cmd_t          cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic                  state_q;
	logic                  state_n;
	lgs_pkg::slot_cnt_t    left_q;
	lgs_pkg::slot_cnt_t    left_n;
	logic                  in_take;
	logic                  out_take;

	// handshakes: a new item may enter as the last result leaves
	always_comb begin
		out_valid = (state_q == ST_EMIT);
		out_take  = out_valid && !out_stall;
		in_stall  = (state_q == ST_EMIT)
			&& !((left_q == lgs_pkg::SLOT_CNT_W'(1)) && out_take);
		in_take   = in_valid && !in_stall;
		cmd.load    = in_take;
		cmd.advance = out_take;
	end

	// next state
	always_comb begin
		state_n = state_q;
		left_n  = left_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					left_n  = sts.new_count;
					state_n = (sts.new_count != '0) ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (in_take) begin
					left_n  = sts.new_count;
					state_n = (sts.new_count != '0) ? ST_EMIT : ST_IDLE;
				end else if (out_take) begin
					left_n  = left_q - lgs_pkg::SLOT_CNT_W'(1);
					state_n = (left_q == lgs_pkg::SLOT_CNT_W'(1)) ? ST_IDLE : ST_EMIT;
				end
			end
			default: begin
				state_n = ST_IDLE;
				left_n  = '0;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
		end else begin
			state_q <= state_n;
			left_q  <= left_n;
		end
	end

	// emitting exactly while results remain
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) == (left_q != '0))
		else $error("emit state and pending count disagree");

	// an item enters during emit only while the final result is taken
	a_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && (state_q == ST_EMIT)) |-> (out_take && (left_q == lgs_pkg::SLOT_CNT_W'(1))))
		else $error("item accepted while results still wait");

	// draining the last result with no new item leaves the block idle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && (left_q == lgs_pkg::SLOT_CNT_W'(1)) && !in_take) |=> !out_valid)
		else $error("result shown after the last one was taken");

endmodule

`default_nettype wire

/* sv/life_generation_stencil.sv */
// Streaming Game of Life (B3/S23) next-generation engine for a square board of
// board_side cells (1..32; 0 acts as 1, larger values as 32), dead beyond the
// edges, no wraparound. Cells enter in raster order, one bit per item, with
// frame_start on row 0 column 0. Each result carries the cell's next state and
// its row and column; results trail the input by one row plus one cell, and the
// last input of a frame flushes the bottom row, ending with frame_end and
// any_alive. Results leave one per cycle while out_stall is low, in delivery
// order from the result slots of one item (the final cell of a frame gives up
// to four). A new item enters in the cycle the last pending result is taken,
// so an item with at most one result stalls the input only while out_stall is high.
// Change board_side only between frames or while idle.
`default_nettype none

module life_generation_stencil (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [5:0]          cfg_wr_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                cell_alive,
	input  wire logic                frame_start,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     next_alive,
	output logic [4:0]               out_row,
	output logic [4:0]               out_column,
	output logic                     frame_end,
	output logic                     any_alive
);

	lgs_pkg::lgs_cmd_t     cmd;
	lgs_pkg::lgs_status_t  sts;

	// handshake and sequencing
	lgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// row buffers, window and result registers
	lgs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cell_alive  (cell_alive),
		.frame_start (frame_start),
		.cmd         (cmd),
		.sts         (sts),
		.next_alive  (next_alive),
		.out_row     (out_row),
		.out_column  (out_column),
		.frame_end   (frame_end),
		.any_alive   (any_alive)
	);

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;

	// neighbor masks of the 3x3 window, oldest column in the low bits
	localparam bit [8:0] UPPER_NEIGHBORS = 9'b111_101_111;
	localparam bit [8:0] LOWER_NEIGHBORS = 9'b110_010_110;

	typedef enum int {FRAME_CLEAN, FRAME_UNMARKED, FRAME_NOISY} frame_kind_t;

	typedef struct packed {
		logic       nxt;
		logic [4:0] row;
		logic [4:0] col;
		logic       last;
		logic       alive_flag;
	} gen_cell_t;

	// next-generation predictor and store of pending cell results
	class life_scoreboard;
		bit [5:0]    side_reg;
		bit          row_above[lgs_pkg::MAX_SIDE];
		bit          row_newest[lgs_pkg::MAX_SIDE];
		bit [8:0]    window;
		int unsigned row_pos;
		int unsigned col_pos;
		bit          gen_alive;
		gen_cell_t   next_gen_q[$];
		int          errors;

		function new();
			side_reg = 6'd32;
			window = '0;
			row_pos = 0;
			col_pos = 0;
			gen_alive = 1'b0;
			errors = 0;
			foreach (row_above[i]) begin
				row_above[i] = 1'b0;
				row_newest[i] = 1'b0;
			end
		endfunction

		function void set_side(bit [5:0] v);
			side_reg = v;
		endfunction

		// out-of-range sides are clamped
		function int unsigned side_used();
			if (side_reg == 0)
				return 1;
			if (side_reg > lgs_pkg::MAX_SIDE)
				return lgs_pkg::MAX_SIDE;
			return side_reg;
		endfunction

		// b3/s23 rule
		function bit next_state(bit center, bit [8:0] nb);
			int n;
			n = $countones(nb);
			return center ? (n == 2 || n == 3) : (n == 3);
		endfunction

		function void push_cell(bit v, int unsigned r, int unsigned c, bit last);
			gen_cell_t e;
			gen_alive |= v;
			e.nxt = v;
			e.row = 5'(r);
			e.col = 5'(c);
			e.last = last;
			e.alive_flag = last ? gen_alive : 1'b0;
			next_gen_q.push_back(e);
		endfunction

		function void note_cell(bit alive, bit start);
			int unsigned s, r, c;
			bit a, b, bottom, right;
			bit [8:0] w, shifted;
			s = side_used();
			r = row_pos;
			c = col_pos;
			// explicit start or stale position restarts the frame
			if (start || r >= s || c >= s) begin
				r = 0;
				c = 0;
			end
			if (r == 0 && c == 0)
				gen_alive = 1'b0;
			// rows above the top edge are dead
			a = (r >= 2) ? row_above[c] : 1'b0;
			b = (r >= 1) ? row_newest[c] : 1'b0;
			row_above[c] = row_newest[c];
			row_newest[c] = alive;
			if (c == 0)
				w = {alive, b, a, 6'b0};
			else
				w = {alive, b, a, window[8:3]};
			window = w;
			bottom = (r == s - 1);
			right = (c == s - 1);
			if (c >= 1) begin
				if (r >= 1)
					push_cell(next_state(w[4], w & UPPER_NEIGHBORS), r - 1, c - 1, 1'b0);
				if (bottom)
					push_cell(next_state(w[5], w & LOWER_NEIGHBORS), r, c - 1, 1'b0);
			end
			// right edge: shift in a dead column
			if (right) begin
				shifted = w >> 3;
				if (r >= 1)
					push_cell(next_state(shifted[4], shifted & UPPER_NEIGHBORS),
						r - 1, s - 1, 1'b0);
				if (bottom)
					push_cell(next_state(shifted[5], shifted & LOWER_NEIGHBORS),
						r, s - 1, 1'b1);
			end
			if (right) begin
				c = 0;
				r = bottom ? 0 : r + 1;
			end else begin
				c = c + 1;
			end
			row_pos = r;
			col_pos = c;
		endfunction

		function void compare(string field, int unsigned want, int unsigned seen);
			if (want != seen) begin
				$display("%0t: %s expected %0d got %0d", $time, field, want, seen);
				errors++;
			end
		endfunction

		function void check_result(gen_cell_t got);
			gen_cell_t e;
			if (next_gen_q.size() == 0) begin
				$display("%0t: result row %0d col %0d with nothing pending",
					$time, got.row, got.col);
				errors++;
				return;
			end
			e = next_gen_q.pop_front();
			compare("next_alive", e.nxt, got.nxt);
			compare("out_row", e.row, got.row);
			compare("out_column", e.col, got.col);
			compare("frame_end", e.last, got.last);
			compare("any_alive", e.alive_flag, got.alive_flag);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [5:0] cfg_wr_data;
	logic       in_valid;
	logic       in_stall;
	logic       cell_alive;
	logic       frame_start;
	logic       out_valid;
	logic       out_stall;
	logic       next_alive;
	logic [4:0] out_row;
	logic [4:0] out_column;
	logic       frame_end;
	logic       any_alive;

	life_scoreboard board = new();
	bit send_quiet;
	int unsigned random_cells;

	life_generation_stencil uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cell_alive  (cell_alive),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.next_alive  (next_alive),
		.out_row     (out_row),
		.out_column  (out_column),
		.frame_end   (frame_end),
		.any_alive   (any_alive)
	);

	// clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int draw_idle(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 16);
	endfunction

	// one cell item, entered and left at a falling edge
	task automatic send_cell(input bit alive, input bit start);
		int gap;
		if ($urandom_range(0, 24) == 0)
			send_quiet = !send_quiet;
		gap = draw_idle(send_quiet);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cell_alive <= alive;
		frame_start <= start;
		do @(posedge clk); while (in_stall);
		board.note_cell(alive, start);
		@(negedge clk);
	endtask

	// hold off input until every pending result is out
	task automatic drain();
		in_valid <= 1'b0;
		while (board.next_gen_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_side(input bit [5:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		board.set_side(v);
	endtask

	// fixed pattern in raster order, frame_start on the first cell
	task automatic send_bits(input bit [31:0] cells, input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_cell(cells[i], i == 0);
	endtask

	task automatic send_frame(input int unsigned count, input int unsigned density,
		input frame_kind_t kind);
		bit start;
		for (int unsigned i = 0; i < count; i++) begin
			case (kind)
				FRAME_CLEAN: start = (i == 0);
				FRAME_UNMARKED: start = 1'b0;
				default: start = ($urandom_range(0, 7) == 0);
			endcase
			send_cell($urandom_range(0, 99) < density, start);
		end
	endtask

	// result side with random stalls
	initial begin
		int n;
		bit quiet;
		gen_cell_t got;
		quiet = 1'b0;
		out_stall = 1'b0;
		forever begin
			if ($urandom_range(0, 24) == 0)
				quiet = !quiet;
			n = draw_idle(quiet);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got.nxt = next_alive;
			got.row = out_row;
			got.col = out_column;
			got.last = frame_end;
			got.alive_flag = any_alive;
			board.check_result(got);
			@(negedge clk);
		end
	end

	// stimulus
	initial begin
		int unsigned s, count;
		frame_kind_t kind;
		int pick;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		cell_alive = 1'b0;
		frame_start = 1'b0;
		send_quiet = 1'b0;
		random_cells = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-cell boards, side zero acts as one
		write_side(6'd1);
		send_bits(32'h1, 1);
		send_bits(32'h0, 1);
		drain();
		write_side(6'd0);
		send_bits(32'h1, 1);
		drain();

		// blinker, then a frame restarted mid-way
		write_side(6'd3);
		send_bits(32'h92, 9);
		send_bits($urandom, 5);
		send_bits($urandom, 4);
		drain();

		// shrink the side while the position sits past it
		write_side(6'd1);
		send_cell(1'b1, 1'b0);
		drain();

		// still-life block
		write_side(6'd2);
		send_bits(32'hF, 4);
		drain();

		// full-size board, then an oversized side, both as partial frames
		write_side(6'd32);
		send_frame(40, 30, FRAME_CLEAN);
		drain();
		write_side(6'd63);
		send_frame(24, 50, FRAME_CLEAN);
		drain();
		write_side(6'd4);

		// random frames, mostly well formed on small boards
		while (random_cells < 40) begin
			if ($urandom_range(0, 2) == 0) begin
				drain();
				if ($urandom_range(0, 9) == 0)
					write_side(6'($urandom_range(0, 8)));
				else
					write_side(6'($urandom_range(1, 6)));
			end
			s = board.side_used();
			pick = $urandom_range(0, 9);
			if (pick == 0)
				kind = FRAME_NOISY;
			else if (pick == 1)
				kind = FRAME_UNMARKED;
			else
				kind = FRAME_CLEAN;
			if (kind == FRAME_CLEAN && $urandom_range(0, 5) != 0)
				count = s * s;
			else
				count = $urandom_range(1, s * s);
			send_frame(count, $urandom_range(0, 4) * 25, kind);
			random_cells += count;
		end
		drain();

		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
